// ===== hw/rtl/i2c_eeprom_master_macros.svh =====
// Assertion macros for the I2C EEPROM master.
`ifndef I2C_EEPROM_MASTER_MACROS_SVH
`define I2C_EEPROM_MASTER_MACROS_SVH

`ifndef SYNTHESIS

`define I2C_EM_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("i2c_em assertion failed");

`define I2C_EM_NEVER(lbl, ck, rstn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
    else $error("i2c_em forbidden condition");

`else

`define I2C_EM_ASSERT(lbl, ck, rstn, prop)

`define I2C_EM_NEVER(lbl, ck, rstn, cond)

`endif

`endif

// ===== hw/rtl/i2c_em_pkg.sv =====
// Shared types and constants of the I2C EEPROM master.
package i2c_em_pkg;

  localparam int unsigned PhaseW = 5;

  localparam logic [PhaseW-1:0] PH_IDLE     = 5'd0;
  localparam logic [PhaseW-1:0] PH_START1   = 5'd1;
  localparam logic [PhaseW-1:0] PH_START2   = 5'd2;
  localparam logic [PhaseW-1:0] PH_START3   = 5'd3;
  localparam logic [PhaseW-1:0] PH_TX_LOW   = 5'd4;
  localparam logic [PhaseW-1:0] PH_TX_HIGH  = 5'd5;
  localparam logic [PhaseW-1:0] PH_ACK_LOW  = 5'd6;
  localparam logic [PhaseW-1:0] PH_ACK_HIGH = 5'd7;
  localparam logic [PhaseW-1:0] PH_RSTART   = 5'd8;
  localparam logic [PhaseW-1:0] PH_RX_LOW   = 5'd9;
  localparam logic [PhaseW-1:0] PH_RX_HIGH  = 5'd10;
  localparam logic [PhaseW-1:0] PH_NAK_LOW  = 5'd11;
  localparam logic [PhaseW-1:0] PH_NAK_HIGH = 5'd12;
  localparam logic [PhaseW-1:0] PH_STOP1    = 5'd13;
  localparam logic [PhaseW-1:0] PH_STOP2    = 5'd14;
  localparam logic [PhaseW-1:0] PH_STOP3    = 5'd15;
  localparam logic [PhaseW-1:0] PH_WAIT     = 5'd16;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] BYTE_DEV  = 2'd0;
  localparam logic [1:0] BYTE_ADDR = 2'd1;
  localparam logic [1:0] BYTE_DATA = 2'd2;
  localparam logic [1:0] BYTE_RX   = 2'd3;

  localparam logic [3:0] DEV_TYPE_ID = 4'b1010;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_WR_RECOVERY = 3'd0;
  localparam logic [15:0] WR_RECOVERY_RESET = 16'd4000;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        bit_cnt;
    logic [7:0]        shift;
    logic [1:0]        byte_idx;
    logic [15:0]       wait_cnt;
    logic              is_read;
    logic [2:0]        chip;
    logic [7:0]        addr;
    logic [7:0]        data;
    logic [7:0]        read_res;
    logic              nack;
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       nack;
  } result_t;

endpackage

// ===== hw/rtl/i2c_eeprom_master.sv =====
// Each accepted word is held in the input register, then moves to the result register, where its result is valid.
// Throughput: one input word and one result word per cycle while out_stall is low; the bus sequencer state
// updates in the same cycle its word moves from the input register to the result register.
// Reset (rst_n low, synchronous): sequencer idle, both registers empty,
// write recovery count back to 4000 ticks.
`include "i2c_eeprom_master_macros.svh"

module i2c_eeprom_master (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [2:0]                      in_chip_select,
  input  logic [7:0]                      in_mem_address,
  input  logic [7:0]                      in_write_data,
  input  logic                            in_sda_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_scl_level,
  output logic                            out_sda_level,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [7:0]                      out_read_byte,
  output logic                            out_nack_seen,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [i2c_em_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  logic                in_vld_r;
  logic [1:0]          cmd_r;
  logic [2:0]          chip_r;
  logic [7:0]          addr_r;
  logic [7:0]          data_r;
  logic                sda_r;
  logic                out_vld_r;
  i2c_em_pkg::result_t res_r;
  i2c_em_pkg::state_t  state_r;
  i2c_em_pkg::state_t  state_nxt;
  i2c_em_pkg::result_t res_nxt;
  logic [15:0]         wr_recovery;
  logic                advance;
  logic                in_take;

  i2c_em_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .wr_recovery (wr_recovery)
  );

  i2c_em_step u_step (
    .cur         (state_r),
    .command     (cmd_r),
    .chip_select (chip_r),
    .mem_address (addr_r),
    .write_data  (data_r),
    .sda_in      (sda_r),
    .wr_recovery (wr_recovery),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // word moves to the result register when that register is free or being drained
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_command;
      chip_r <= in_chip_select;
      addr_r <= in_mem_address;
      data_r <= in_write_data;
      sda_r  <= in_sda_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_scl_level = res_r.scl;
  assign out_sda_level = res_r.sda;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_read_byte = res_r.read_byte;
  assign out_nack_seen = res_r.nack;

  `I2C_EM_ASSERT(a_done_is_busy, clk, rst_n, out_valid && out_done_res |-> out_busy_res)
  `I2C_EM_ASSERT(a_done_to_idle, clk, rst_n,
    advance && res_nxt.done |=> state_r.phase == i2c_em_pkg::PH_IDLE)
  `I2C_EM_ASSERT(a_state_holds, clk, rst_n, !advance |=> $stable(state_r))
  `I2C_EM_NEVER(a_phase_range, clk, rst_n, state_r.phase > i2c_em_pkg::PH_WAIT)

endmodule

// ===== hw/rtl/i2c_em_cfg.sv =====
// APB register file holding the write recovery tick count.
module i2c_em_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [i2c_em_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output logic [15:0]                    wr_recovery
);

  logic [15:0] wr_recovery_r;
  logic [15:0] wr_recovery_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    wr_recovery_nxt = wr_recovery_r;
    if (wr_en && cfg_paddr == i2c_em_pkg::REG_WR_RECOVERY) begin
      wr_recovery_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_recovery_r <= i2c_em_pkg::WR_RECOVERY_RESET;
    end else begin
      wr_recovery_r <= wr_recovery_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      i2c_em_pkg::REG_WR_RECOVERY: cfg_prdata = {16'd0, wr_recovery_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  assign wr_recovery = wr_recovery_r;

endmodule

// ===== hw/rtl/i2c_em_step.sv =====
// Bus phase sequencer: next state and line levels for one tick.
module i2c_em_step (
  input  i2c_em_pkg::state_t  cur,
  input  logic [1:0]          command,
  input  logic [2:0]          chip_select,
  input  logic [7:0]          mem_address,
  input  logic [7:0]          write_data,
  input  logic                sda_in,
  input  logic [15:0]         wr_recovery,
  output i2c_em_pkg::state_t  nxt,
  output i2c_em_pkg::result_t res
);

  i2c_em_pkg::state_t s;
  logic scl_o;
  logic sda_o;
  logic busy;
  logic done;
  logic [3:0] bc_inc;
  logic [15:0] wait_dec;

  always_comb begin
    s = cur;
    scl_o = 1'b1;
    sda_o = 1'b1;
    busy  = 1'b1;
    done  = 1'b0;

    if (s.phase > i2c_em_pkg::PH_WAIT) begin
      s.phase = i2c_em_pkg::PH_IDLE;
    end

    if (s.phase == i2c_em_pkg::PH_IDLE &&
        (command == i2c_em_pkg::CMD_WRITE || command == i2c_em_pkg::CMD_READ)) begin
      s.is_read  = (command == i2c_em_pkg::CMD_READ);
      s.chip     = chip_select;
      s.addr     = mem_address;
      s.data     = write_data;
      s.nack     = 1'b0;
      s.byte_idx = i2c_em_pkg::BYTE_DEV;
      s.bit_cnt  = 4'd0;
      s.phase    = i2c_em_pkg::PH_START1;
    end

    bc_inc   = s.bit_cnt + 4'd1;
    wait_dec = s.wait_cnt - 16'd1;

    unique case (s.phase)
      i2c_em_pkg::PH_START1: begin
        s.phase = i2c_em_pkg::PH_START2;
      end
      i2c_em_pkg::PH_START2: begin
        sda_o = 1'b0;
        s.phase = i2c_em_pkg::PH_START3;
      end
      i2c_em_pkg::PH_START3: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
        // device byte; R/W bit set on the repeated start of a read
        s.shift   = {i2c_em_pkg::DEV_TYPE_ID, s.chip,
                     s.byte_idx == i2c_em_pkg::BYTE_DATA};
        s.bit_cnt = 4'd0;
        s.phase   = i2c_em_pkg::PH_TX_LOW;
      end
      i2c_em_pkg::PH_TX_LOW: begin
        scl_o = 1'b0;
        sda_o = s.shift[7];
        s.phase = i2c_em_pkg::PH_TX_HIGH;
      end
      i2c_em_pkg::PH_TX_HIGH: begin
        sda_o = s.shift[7];
        s.shift = {s.shift[6:0], 1'b0};
        s.bit_cnt = bc_inc;
        s.phase = (bc_inc >= i2c_em_pkg::BITS_PER_BYTE) ? i2c_em_pkg::PH_ACK_LOW
                                                         : i2c_em_pkg::PH_TX_LOW;
      end
      i2c_em_pkg::PH_ACK_LOW: begin
        scl_o = 1'b0;
        s.phase = i2c_em_pkg::PH_ACK_HIGH;
      end
      i2c_em_pkg::PH_ACK_HIGH: begin
        s.nack = s.nack | sda_in;
        if (s.byte_idx == i2c_em_pkg::BYTE_DEV) begin
          s.byte_idx = i2c_em_pkg::BYTE_ADDR;
          s.shift    = s.addr;
          s.bit_cnt  = 4'd0;
          s.phase    = i2c_em_pkg::PH_TX_LOW;
        end else if (s.byte_idx == i2c_em_pkg::BYTE_ADDR) begin
          s.byte_idx = i2c_em_pkg::BYTE_DATA;
          if (s.is_read) begin
            s.phase = i2c_em_pkg::PH_RSTART;
          end else begin
            s.shift   = s.data;
            s.bit_cnt = 4'd0;
            s.phase   = i2c_em_pkg::PH_TX_LOW;
          end
        end else if (s.byte_idx == i2c_em_pkg::BYTE_DATA && s.is_read) begin
          s.byte_idx = i2c_em_pkg::BYTE_RX;
          s.shift    = 8'd0;
          s.bit_cnt  = 4'd0;
          s.phase    = i2c_em_pkg::PH_RX_LOW;
        end else begin
          s.phase = i2c_em_pkg::PH_STOP1;
        end
      end
      i2c_em_pkg::PH_RSTART: begin
        scl_o = 1'b0;
        s.phase = i2c_em_pkg::PH_START1;
      end
      i2c_em_pkg::PH_RX_LOW: begin
        scl_o = 1'b0;
        s.phase = i2c_em_pkg::PH_RX_HIGH;
      end
      i2c_em_pkg::PH_RX_HIGH: begin
        s.shift = {s.shift[6:0], sda_in};
        s.bit_cnt = bc_inc;
        s.phase = (bc_inc >= i2c_em_pkg::BITS_PER_BYTE) ? i2c_em_pkg::PH_NAK_LOW
                                                         : i2c_em_pkg::PH_RX_LOW;
      end
      i2c_em_pkg::PH_NAK_LOW: begin
        scl_o = 1'b0;
        s.phase = i2c_em_pkg::PH_NAK_HIGH;
      end
      i2c_em_pkg::PH_NAK_HIGH: begin
        s.phase = i2c_em_pkg::PH_STOP1;
      end
      i2c_em_pkg::PH_STOP1: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
        s.phase = i2c_em_pkg::PH_STOP2;
      end
      i2c_em_pkg::PH_STOP2: begin
        sda_o = 1'b0;
        s.phase = i2c_em_pkg::PH_STOP3;
      end
      i2c_em_pkg::PH_STOP3: begin
        if (s.is_read) begin
          s.read_res = s.shift;
          done = 1'b1;
          s.phase = i2c_em_pkg::PH_IDLE;
        end else if (wr_recovery == 16'd0) begin
          done = 1'b1;
          s.phase = i2c_em_pkg::PH_IDLE;
        end else begin
          s.wait_cnt = wr_recovery;
          s.phase = i2c_em_pkg::PH_WAIT;
        end
      end
      i2c_em_pkg::PH_WAIT: begin
        if (s.wait_cnt != 16'd0) begin
          s.wait_cnt = wait_dec;
        end
        if (s.wait_cnt == 16'd0) begin
          done = 1'b1;
          s.phase = i2c_em_pkg::PH_IDLE;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase

    nxt = s;
    res.scl       = scl_o;
    res.sda       = sda_o;
    res.busy      = busy;
    res.done      = done;
    res.read_byte = s.read_res;
    res.nack      = s.nack;
  end

endmodule
